### rtl/partition_fit_allocator_unit_defines.svh
`ifndef PARTITION_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PFA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pfa_pkg.sv
package pfa_pkg;

  localparam int PARTITIONS_DEF = 8;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int KIND_W    = 1;
  localparam int EIDX_W    = 3;
  localparam int FSIZE_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int BIDX_W    = 3;
  localparam int TOTAL_W   = 19;
  localparam int POLICY_W  = 2;
  localparam int PIU_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ALLOC  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT  = 2'd2;

  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIU    = 1'b1;

  localparam logic [POLICY_W-1:0] POLICY_RST = POLICY_FIRST;
  localparam logic [PIU_W-1:0]    PIU_RST    = 4'd6;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_TOTAL  = 3'b100
  } pfa_state_e;

endpackage

### rtl/partition_fit_allocator_unit.sv
// A load transaction runs a totals pass; an allocation runs a search pass and then a totals pass,
// each over the partitions in use after saturation.
// One transaction at a time, one memory entry read per cycle; busy_o drops in the result cycle.
// Reset: policy first fit, six partitions in use, all sizes zero, all partitions free.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
`include "partition_fit_allocator_unit_defines.svh"

module partition_fit_allocator_unit #(
  parameter int PARTITIONS = pfa_pkg::PARTITIONS_DEF,
  parameter int SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pfa_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [pfa_pkg::KIND_W-1:0]     kind_i,
  input  logic [pfa_pkg::EIDX_W-1:0]     entry_index_i,
  input  logic [pfa_pkg::FSIZE_W-1:0]    entry_size_i,
  input  logic [pfa_pkg::FSIZE_W-1:0]    request_size_i,
  output logic                           done_o,
  output logic [pfa_pkg::STATUS_W-1:0]   status_o,
  output logic [pfa_pkg::BIDX_W-1:0]     block_index_o,
  output logic [pfa_pkg::FSIZE_W-1:0]    block_size_o,
  output logic [pfa_pkg::TOTAL_W-1:0]    total_free_o,
  output logic [pfa_pkg::FSIZE_W-1:0]    largest_free_o,
  output logic [pfa_pkg::TOTAL_W-1:0]    fragmentation_o
);

  localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_W = $clog2(PARTITIONS + 1);
  localparam int SZW   = (SIZE_BITS > pfa_pkg::FSIZE_W) ? SIZE_BITS : pfa_pkg::FSIZE_W;
  localparam int TOT_W = SIZE_BITS + CNT_W;

  pfa_pkg::pfa_state_e state_q, state_d;

  logic [pfa_pkg::POLICY_W-1:0] policy_q;
  logic [pfa_pkg::PIU_W-1:0]    piu_q;
  logic [pfa_pkg::FSIZE_W-1:0]  req_q;
  logic [CNT_W-1:0]             n_q, n_d;
  logic [CNT_W-1:0]             cnt_q;
  logic                         rd_vld_q;
  logic [IDX_W-1:0]             rd_idx_q;
  logic [PARTITIONS-1:0]        taken_q;
  logic                         found_q;
  logic [IDX_W-1:0]             pick_q;
  logic [SIZE_BITS-1:0]         pick_size_q;
  logic [pfa_pkg::STATUS_W-1:0] status_q;
  logic [TOT_W-1:0]             total_q;
  logic [SIZE_BITS-1:0]         largest_q;
  logic                         done_q;

  logic                 accept;
  logic                 load_ok;
  logic                 scanning;
  logic                 issue;
  logic                 pass_end;
  logic [SIZE_BITS-1:0] rd_size;
  logic                 rd_free;
  logic                 fits;
  logic                 better;

  assign accept   = start_i && (state_q == pfa_pkg::ST_IDLE);
  assign load_ok  = accept && (kind_i == pfa_pkg::KIND_LOAD) &&
                    (int'(entry_index_i) < PARTITIONS);
  assign scanning = (state_q == pfa_pkg::ST_SEARCH) || (state_q == pfa_pkg::ST_TOTAL);
  assign issue    = scanning && (cnt_q < n_q);
  assign pass_end = scanning && !issue && !rd_vld_q;

  always_comb begin
    if (int'(piu_q) > PARTITIONS) begin
      n_d = CNT_W'(PARTITIONS);
    end else begin
      n_d = CNT_W'(piu_q);
    end
  end

  pfa_size_mem #(
    .PARTITIONS (PARTITIONS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_size_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (load_ok),
    .waddr_i (IDX_W'(entry_index_i)),
    .wdata_i (SIZE_BITS'(entry_size_i)),
    .re_i    (issue),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (rd_size)
  );

  assign rd_free = rd_vld_q && !taken_q[rd_idx_q];
  assign fits    = rd_free && (SZW'(rd_size) >= SZW'(req_q));

  always_comb begin
    case (policy_q)
      pfa_pkg::POLICY_BEST:  better = rd_size < pick_size_q;
      pfa_pkg::POLICY_WORST: better = rd_size > pick_size_q;
      default:               better = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (kind_i == pfa_pkg::KIND_ALLOC) ? pfa_pkg::ST_SEARCH : pfa_pkg::ST_TOTAL;
        end
      end
      pfa_pkg::ST_SEARCH: begin
        if (pass_end) begin
          state_d = pfa_pkg::ST_TOTAL;
        end
      end
      pfa_pkg::ST_TOTAL: begin
        if (pass_end) begin
          state_d = pfa_pkg::ST_IDLE;
        end
      end
      default: state_d = pfa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pfa_pkg::ST_IDLE;
      policy_q <= pfa_pkg::POLICY_RST;
      piu_q    <= pfa_pkg::PIU_RST;
      taken_q  <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= (state_q == pfa_pkg::ST_TOTAL) && pass_end;
      rd_vld_q <= issue;
      if (cfg_we_i) begin
        case (cfg_index_i)
          pfa_pkg::CFG_POLICY: policy_q <= cfg_wdata_i[pfa_pkg::POLICY_W-1:0];
          pfa_pkg::CFG_PIU:    piu_q    <= cfg_wdata_i[pfa_pkg::PIU_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pass_end) begin
        cnt_q <= '0;
      end
      if (load_ok) begin
        taken_q[IDX_W'(entry_index_i)] <= 1'b0;
      end else if ((state_q == pfa_pkg::ST_SEARCH) && pass_end && found_q) begin
        taken_q[pick_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= cnt_q[IDX_W-1:0];
    end
    if (accept) begin
      n_q         <= n_d;
      req_q       <= request_size_i;
      found_q     <= 1'b0;
      pick_q      <= '0;
      pick_size_q <= '0;
      total_q     <= '0;
      largest_q   <= '0;
      status_q    <= pfa_pkg::STATUS_LOADED;
    end else if (state_q == pfa_pkg::ST_SEARCH) begin
      if (fits && (!found_q || better)) begin
        found_q     <= 1'b1;
        pick_q      <= rd_idx_q;
        pick_size_q <= rd_size;
      end
      if (pass_end) begin
        status_q <= found_q ? pfa_pkg::STATUS_ALLOC : pfa_pkg::STATUS_NOFIT;
      end
    end else if (state_q == pfa_pkg::ST_TOTAL) begin
      if (rd_free) begin
        total_q <= total_q + TOT_W'(rd_size);
        if (rd_size > largest_q) begin
          largest_q <= rd_size;
        end
      end
    end
  end

  assign busy_o          = (state_q != pfa_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign block_index_o   = pfa_pkg::BIDX_W'(pick_q);
  assign block_size_o    = pfa_pkg::FSIZE_W'(pick_size_q);
  assign total_free_o    = pfa_pkg::TOTAL_W'(total_q);
  assign largest_free_o  = pfa_pkg::FSIZE_W'(largest_q);
  assign fragmentation_o = pfa_pkg::TOTAL_W'(total_q) - pfa_pkg::TOTAL_W'(largest_q);

  `PFA_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "accepted transaction not busy")
  `PFA_ASSERT_IMPL(a_done_from_total, done_o, $past(state_q == pfa_pkg::ST_TOTAL) && !busy_o, "done without totals pass")
  `PFA_ASSERT_IMPL(a_alloc_fits, done_o && (status_o == pfa_pkg::STATUS_ALLOC), SZW'(pick_size_q) >= SZW'(req_q), "granted partition smaller than request")
  `PFA_ASSERT_IMPL(a_nogrant_zero, done_o && (status_o != pfa_pkg::STATUS_ALLOC), (pick_q == '0) && (pick_size_q == '0), "grant fields set without grant")

endmodule

### rtl/pfa_size_mem.sv
module pfa_size_mem #(
  parameter int PARTITIONS = pfa_pkg::PARTITIONS_DEF,
  parameter int SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF,
  localparam int IDX_W     = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [IDX_W-1:0]     waddr_i,
  input  logic [SIZE_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [IDX_W-1:0]     raddr_i,
  output logic [SIZE_BITS-1:0] rdata_o
);

  logic [SIZE_BITS-1:0]  mem_q [PARTITIONS];
  logic [PARTITIONS-1:0] valid_q;
  logic [SIZE_BITS-1:0]  rdata_q;
  logic                  rok_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rok_q   <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rok_q <= valid_q[raddr_i];
      end
    end
  end

  // never-loaded entries read as zero
  assign rdata_o = rok_q ? rdata_q : '0;

endmodule

### bench/tb_partition_fit_allocator_unit.sv
`timescale 1ns / 100ps

typedef struct packed {
  logic [pfa_pkg::STATUS_W-1:0] status;
  logic [pfa_pkg::BIDX_W-1:0]   block_index;
  logic [pfa_pkg::FSIZE_W-1:0]  block_size;
  logic [pfa_pkg::TOTAL_W-1:0]  total_free;
  logic [pfa_pkg::FSIZE_W-1:0]  largest_free;
  logic [pfa_pkg::TOTAL_W-1:0]  fragmentation;
} alloc_result_t;

class alloc_scoreboard;
  logic [pfa_pkg::POLICY_W-1:0] policy;
  logic [pfa_pkg::PIU_W-1:0]    in_use;
  logic [pfa_pkg::FSIZE_W-1:0]  part_size [pfa_pkg::PARTITIONS_DEF];
  bit                           part_taken [pfa_pkg::PARTITIONS_DEF];
  alloc_result_t                expected_q [$];
  int                           errors;
  int                           loads;
  int                           grants;
  int                           misses;

  function new();
    policy = pfa_pkg::POLICY_RST;
    in_use = pfa_pkg::PIU_RST;
    for (int i = 0; i < pfa_pkg::PARTITIONS_DEF; i++) begin
      part_size[i]  = '0;
      part_taken[i] = 1'b0;
    end
    errors = 0;
    loads  = 0;
    grants = 0;
    misses = 0;
  endfunction

  function void write_reg(logic [pfa_pkg::CFG_IDX_W-1:0] idx,
                          logic [pfa_pkg::CFG_DAT_W-1:0] data);
    if (idx == pfa_pkg::CFG_POLICY) begin
      policy = data[pfa_pkg::POLICY_W-1:0];
    end else begin
      in_use = data[pfa_pkg::PIU_W-1:0];
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // predict the result of one accepted transaction and update the partition table
  function void note_item(logic [pfa_pkg::KIND_W-1:0] kind, logic [pfa_pkg::EIDX_W-1:0] eidx,
                          logic [pfa_pkg::FSIZE_W-1:0] esize,
                          logic [pfa_pkg::FSIZE_W-1:0] req);
    alloc_result_t               r;
    int                          n;
    int                          pick;
    bit                          found;
    logic [pfa_pkg::TOTAL_W-1:0] total;
    logic [pfa_pkg::FSIZE_W-1:0] largest;
    n       = (int'(in_use) > pfa_pkg::PARTITIONS_DEF) ? pfa_pkg::PARTITIONS_DEF : int'(in_use);
    r       = '0;
    found   = 1'b0;
    pick    = 0;
    total   = '0;
    largest = '0;
    if (kind == pfa_pkg::KIND_LOAD) begin
      part_size[eidx]  = esize;
      part_taken[eidx] = 1'b0;
      r.status         = pfa_pkg::STATUS_LOADED;
      loads++;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!part_taken[i] && part_size[i] >= req) begin
          if (!found) begin
            found = 1'b1;
            pick  = i;
          end else if (policy == pfa_pkg::POLICY_BEST && part_size[i] < part_size[pick]) begin
            pick = i;
          end else if (policy == pfa_pkg::POLICY_WORST && part_size[i] > part_size[pick]) begin
            pick = i;
          end
        end
      end
      if (found) begin
        part_taken[pick] = 1'b1;
        r.status         = pfa_pkg::STATUS_ALLOC;
        r.block_index    = pick[pfa_pkg::BIDX_W-1:0];
        r.block_size     = part_size[pick];
        grants++;
      end else begin
        r.status = pfa_pkg::STATUS_NOFIT;
        misses++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!part_taken[i]) begin
        total = total + pfa_pkg::TOTAL_W'(part_size[i]);
        if (part_size[i] > largest) begin
          largest = part_size[i];
        end
      end
    end
    r.total_free    = total;
    r.largest_free  = largest;
    r.fragmentation = total - pfa_pkg::TOTAL_W'(largest);
    expected_q.push_back(r);
  endfunction

  function void cmp_field(string name, logic [pfa_pkg::TOTAL_W-1:0] want,
                          logic [pfa_pkg::TOTAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(alloc_result_t act);
    alloc_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t unexpected result: expected none, actual status %0d", $time, act.status);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    cmp_field("status", pfa_pkg::TOTAL_W'(want.status), pfa_pkg::TOTAL_W'(act.status));
    cmp_field("block_index", pfa_pkg::TOTAL_W'(want.block_index),
              pfa_pkg::TOTAL_W'(act.block_index));
    cmp_field("block_size", pfa_pkg::TOTAL_W'(want.block_size),
              pfa_pkg::TOTAL_W'(act.block_size));
    cmp_field("total_free", want.total_free, act.total_free);
    cmp_field("largest_free", pfa_pkg::TOTAL_W'(want.largest_free),
              pfa_pkg::TOTAL_W'(act.largest_free));
    cmp_field("fragmentation", want.fragmentation, act.fragmentation);
  endfunction
endclass

module tb_partition_fit_allocator_unit;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 96;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          cfg_we_i       = 1'b0;
  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [pfa_pkg::CFG_DAT_W-1:0] cfg_wdata_i    = '0;
  logic                          start_i        = 1'b0;
  logic [pfa_pkg::KIND_W-1:0]    kind_i         = '0;
  logic [pfa_pkg::EIDX_W-1:0]    entry_index_i  = '0;
  logic [pfa_pkg::FSIZE_W-1:0]   entry_size_i   = '0;
  logic [pfa_pkg::FSIZE_W-1:0]   request_size_i = '0;
  logic                          busy_o;
  logic                          done_o;
  logic [pfa_pkg::STATUS_W-1:0]  status_o;
  logic [pfa_pkg::BIDX_W-1:0]    block_index_o;
  logic [pfa_pkg::FSIZE_W-1:0]   block_size_o;
  logic [pfa_pkg::TOTAL_W-1:0]   total_free_o;
  logic [pfa_pkg::FSIZE_W-1:0]   largest_free_o;
  logic [pfa_pkg::TOTAL_W-1:0]   fragmentation_o;

  int              idle_cycles = 0;
  int              phases      = 0;
  bit              steady      = 1'b0;
  alloc_scoreboard sb          = new();

  partition_fit_allocator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .entry_index_i  (entry_index_i),
    .entry_size_i   (entry_size_i),
    .request_size_i (request_size_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .block_index_o  (block_index_o),
    .block_size_o   (block_size_o),
    .total_free_o   (total_free_o),
    .largest_free_o (largest_free_o),
    .fragmentation_o(fragmentation_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result({status_o, block_index_o, block_size_o,
                       total_free_o, largest_free_o, fragmentation_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("tb_partition_fit_allocator_unit failed");
    $finish;
  end

  function automatic logic [pfa_pkg::FSIZE_W-1:0] rand_size();
    int unsigned v;
    case ($urandom_range(0, 7))
      0: begin
        v = 0;
      end
      1: begin
        v = 32'hFFFF;
      end
      2, 3: begin
        v = $urandom_range(0, 15) * 16;
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v[pfa_pkg::FSIZE_W-1:0];
  endfunction

  // start stays high across back-to-back transactions
  task automatic send_item(logic [pfa_pkg::KIND_W-1:0] kind, logic [pfa_pkg::EIDX_W-1:0] eidx,
                           logic [pfa_pkg::FSIZE_W-1:0] esize,
                           logic [pfa_pkg::FSIZE_W-1:0] req);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    kind_i         <= kind;
    entry_index_i  <= eidx;
    entry_size_i   <= esize;
    request_size_i <= req;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(kind, eidx, esize, req);
  endtask

  task automatic load(logic [pfa_pkg::EIDX_W-1:0] eidx, logic [pfa_pkg::FSIZE_W-1:0] esize);
    send_item(pfa_pkg::KIND_LOAD, eidx, esize, pfa_pkg::FSIZE_W'($urandom));
  endtask

  task automatic alloc(logic [pfa_pkg::FSIZE_W-1:0] req);
    send_item(pfa_pkg::KIND_ALLOC, pfa_pkg::EIDX_W'($urandom), pfa_pkg::FSIZE_W'($urandom), req);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic configure(logic [pfa_pkg::CFG_DAT_W-1:0] pol,
                           logic [pfa_pkg::CFG_DAT_W-1:0] piu);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= pfa_pkg::CFG_POLICY;
    cfg_wdata_i <= pol;
    @(posedge clk_i);
    sb.write_reg(pfa_pkg::CFG_POLICY, pol);
    cfg_index_i <= pfa_pkg::CFG_PIU;
    cfg_wdata_i <= piu;
    @(posedge clk_i);
    sb.write_reg(pfa_pkg::CFG_PIU, piu);
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  initial begin
    logic [pfa_pkg::CFG_DAT_W-1:0] pol;
    logic [pfa_pkg::CFG_DAT_W-1:0] piu;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: first fit, six in use, all sizes zero
    alloc(16'd0);
    load(3'd0, 16'hFFFF);
    load(3'd1, 16'd100);
    load(3'd2, 16'd300);
    load(3'd3, 16'd200);
    load(3'd4, 16'd300);
    load(3'd7, 16'hFFFF);
    alloc(16'd150);
    alloc(16'hFFFF);

    // best fit, oversized count saturates
    configure(4'd1, 4'd15);
    alloc(16'hFFFF);
    load(3'd0, 16'hFFFF);
    alloc(16'd150);
    alloc(16'd250);

    // worst fit with ties
    configure(4'd2, 4'd8);
    load(3'd3, 16'd200);
    load(3'd2, 16'd300);
    alloc(16'd1);
    alloc(16'd1);
    alloc(16'd0);

    // unused policy code, nothing in use
    configure(4'd3, 4'd0);
    alloc(16'd0);
    load(3'd5, 16'd7);

    // upper data bits ignored by policy, single partition
    configure(4'b1100, 4'd1);
    alloc(16'd0);
    load(3'd0, 16'h8000);
    alloc(16'h8000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pol = (p < 8) ? pfa_pkg::CFG_DAT_W'(p % 4) : pfa_pkg::CFG_DAT_W'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        pol[3:2] = 2'($urandom_range(0, 3));
      end
      case (p)
        0: piu = 4'd8;
        1: piu = 4'd1;
        2: piu = 4'd15;
        3: piu = 4'd0;
        default: piu = pfa_pkg::CFG_DAT_W'($urandom_range(1, 15));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      configure(pol, piu);
      for (int s = 0; s < pfa_pkg::PARTITIONS_DEF; s++) begin
        load(pfa_pkg::EIDX_W'(s), rand_size());
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 45) begin
          alloc(rand_size());
        end else begin
          load(pfa_pkg::EIDX_W'($urandom_range(0, 7)), rand_size());
        end
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d load and %0d allocation transactions (%0d granted, %0d no fit)",
             sb.loads, sb.grants + sb.misses, sb.grants, sb.misses);
    $display("over %0d register settings plus the reset settings", phases);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_partition_fit_allocator_unit passed");
    end else begin
      $display("tb_partition_fit_allocator_unit failed");
    end
    $finish;
  end
endmodule
